/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, quiet while in reset.
`define SFC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define SFC_ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define SFC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

/* src/sfc_pkg.sv */
package sfc_pkg;

  // Input operation codes
  localparam logic [1:0] OP_REG_READ    = 2'd0;
  localparam logic [1:0] OP_REG_WRITE   = 2'd1;
  localparam logic [1:0] OP_DIRECT_READ = 2'd2;
  localparam logic [1:0] OP_REPLY       = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_XFER = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Register offsets
  localparam logic [23:0] OFS_CTRL0     = 24'h000000;
  localparam logic [23:0] OFS_CTRL1     = 24'h00000C;
  localparam logic [23:0] OFS_EXT_INDEX = 24'h00001E;
  localparam logic [23:0] OFS_EXT_DATA  = 24'h00001F;

  // Extension register indexes
  localparam logic [7:0] EXT_SEND_COUNT = 8'h05;
  localparam logic [7:0] EXT_RECV_COUNT = 8'h06;

  // Control 0 bits and flash opcodes
  localparam int unsigned EXEC_BIT  = 16;
  localparam int unsigned CLEAR_BIT = 20;
  localparam logic [7:0] READ_OPCODE = 8'h03;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] address;
    logic [31:0] write_data;
    logic [3:0]  access_size;
    logic [7:0]  reply_byte;
  } sfc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] read_data;
    logic [7:0]  transmit_byte;
    logic        chip_select;
  } sfc_out_t;

  typedef enum logic [1:0] {
    CMD_REG_READ,
    CMD_REG_WRITE,
    CMD_DIRECT_READ,
    CMD_REPLY
  } cmd_e;

  typedef enum logic [2:0] {
    REG_CTRL0,
    REG_CTRL1,
    REG_EXT_INDEX,
    REG_EXT_DATA,
    REG_OTHER
  } reg_e;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    cmd_e        kind;
    reg_e        regsel;
    logic [23:0] address;
    logic [31:0] data;
    logic [2:0]  size_m1;
    logic [7:0]  reply;
  } sfc_cmd_t;

endpackage

/* src/spi_flash_command_controller_core.sv */
// Channel   Handshake     Payload                 Transaction
// input     push / full   in_item_i  (sfc_in_t)   push && !full
// result    empty / pop   out_item_o (sfc_out_t)  pop && !empty
//
// Cycles: one transaction per cycle unless the result queue is full; every item runs
//   in a single back-end step. An accepted transaction is registered in the command
//   queue, then its result in the result queue (one register stage each) before output.
// The ring byte is prefetched from a registered-read RAM, so it never stalls.
// Reset: asynchronous, clears both queues, all control registers and the ring valid bits;
//   ring entries not yet written read as zero.
// Stalls: a full result queue holds the back end; a full command queue raises full.
module spi_flash_command_controller_core #(
  parameter int unsigned RING_DEPTH  = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  sfc_pkg::sfc_in_t in_item_i,
  output logic             empty,
  input  logic             pop,
  output sfc_pkg::sfc_out_t out_item_o
);

  import sfc_pkg::*;

  sfc_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_pop;
  sfc_out_t res;
  logic     res_push;
  logic     res_full;

  // Front end: classify each transaction and queue it
  sfc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: registers, ring, transfer sequencer; one item per cycle unless results are full
  sfc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue: hold finished results until popped
  sfc_fifo #(
    .WIDTH ($bits(sfc_out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

/* src/sfc_ram.sv */
module sfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sfc_fifo.sv */
module sfc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* src/sfc_front.sv */
module sfc_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfc_pkg::sfc_in_t  item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output sfc_pkg::sfc_cmd_t cmd_o,
  input  logic              cmd_pop_i
);

  import sfc_pkg::*;

  sfc_cmd_t cls;
  logic     cmd_empty;

  // Decode operation, register offset and clamp the direct-read size
  always_comb begin
    cls.address = item_i.address;
    cls.data    = item_i.write_data;
    cls.reply   = item_i.reply_byte;

    case (item_i.operation)
      OP_REG_READ:    cls.kind = CMD_REG_READ;
      OP_REG_WRITE:   cls.kind = CMD_REG_WRITE;
      OP_DIRECT_READ: cls.kind = CMD_DIRECT_READ;
      OP_REPLY:       cls.kind = CMD_REPLY;
      default:        cls.kind = CMD_REPLY;
    endcase

    case (item_i.address)
      OFS_CTRL0:     cls.regsel = REG_CTRL0;
      OFS_CTRL1:     cls.regsel = REG_CTRL1;
      OFS_EXT_INDEX: cls.regsel = REG_EXT_INDEX;
      OFS_EXT_DATA:  cls.regsel = REG_EXT_DATA;
      default:       cls.regsel = REG_OTHER;
    endcase

    if (item_i.access_size == 4'd0) begin
      cls.size_m1 = 3'd0;
    end else if (item_i.access_size inside {[4'd9:4'd15]}) begin
      cls.size_m1 = 3'd7;
    end else begin
      cls.size_m1 = 3'(item_i.access_size - 4'd1);
    end
  end

  sfc_fifo #(
    .WIDTH ($bits(sfc_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

/* src/sfc_back.sv */
module sfc_back #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  sfc_pkg::sfc_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sfc_pkg::sfc_out_t res_o
);

  import sfc_pkg::*;

  localparam int unsigned PW  = $clog2(RING_DEPTH);
  localparam int unsigned WPW = (PW > 3) ? PW : 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD_OP,
    PH_CMD_TX,
    PH_CMD_RX,
    PH_DA_HDR,
    PH_DA_DATA
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [31:0]       ctrl_q, ctrl_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [7:0]        ext_idx_q, ext_idx_d;
  logic [7:0]        send_q, send_d;
  logic [7:0]        recv_q, recv_d;
  logic [7:0]        left_q, left_d;
  logic [WPW-1:0]    wp_q, wp_d;
  logic [63:0]       word_q, word_d;
  logic [23:0]       paddr_q, paddr_d;
  logic [RING_DEPTH-1:0] vld_q, vld_d;
  logic              rvld_q, rvld_d;
  logic              byp_q, byp_d;
  logic [7:0]        byp_data_q, byp_data_d;

  logic              fire;
  logic [PW-1:0]     rp_inc;
  logic [PW-1:0]     wp_ring;
  logic [PW-1:0]     wp_ring_inc;
  logic [WPW-1:0]    rp_ext;
  logic [7:0]        step_cnt;
  logic [7:0]        left_dec;
  logic [1:0]        hdr_sel;
  logic [31:0]       cw;
  logic              ring_we;
  logic [PW-1:0]     ring_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        ring_byte;

  assign fire        = cmd_valid_i && !res_full_i;
  assign cmd_pop_o   = fire;
  assign rp_inc      = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : rp_q + PW'(1);
  assign wp_ring     = wp_q[PW-1:0];
  assign wp_ring_inc = (wp_ring == PW'(RING_DEPTH - 1)) ? '0 : wp_ring + PW'(1);
  assign left_dec    = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
  assign hdr_sel     = 2'(left_q - 8'd1);
  // A byte written in the previous cycle at the prefetched address wins over the RAM
  assign ring_byte   = byp_q ? byp_data_q : (rvld_q ? ram_rdata : 8'd0);

  always_comb begin
    phase_d    = phase_q;
    ctrl_d     = ctrl_q;
    rp_d       = rp_q;
    ext_idx_d  = ext_idx_q;
    send_d     = send_q;
    recv_d     = recv_q;
    left_d     = left_q;
    wp_d       = wp_q;
    word_d     = word_q;
    paddr_d    = paddr_q;
    vld_d      = vld_q;
    ring_we    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{kind: KIND_READ, read_data: 64'd0, transmit_byte: 8'd0,
                   chip_select: 1'b1};
    step_cnt   = (phase_q == PH_CMD_OP) ? send_q : left_q;
    cw         = cmd_i.data;
    rp_ext     = '0;

    if (fire) begin
      if (cmd_i.kind == CMD_REPLY) begin
        case (phase_q)
          PH_CMD_OP, PH_CMD_TX: begin
            if (step_cnt == 8'd0) begin
              // Send phase over: receive at the pointer left after sending
              rp_d       = wp_ring;
              res_push_o = 1'b1;
              if (recv_q == 8'd0) begin
                ctrl_d[EXEC_BIT] = 1'b0;
                phase_d          = PH_IDLE;
                left_d           = 8'd0;
                res_o.kind       = KIND_DONE;
              end else begin
                phase_d           = PH_CMD_RX;
                left_d            = recv_q;
                res_o.kind        = KIND_XFER;
                res_o.chip_select = 1'b0;
              end
            end else begin
              wp_d                = WPW'(wp_ring_inc);
              left_d              = step_cnt - 8'd1;
              phase_d             = PH_CMD_TX;
              res_push_o          = 1'b1;
              res_o.kind          = KIND_XFER;
              res_o.transmit_byte = ring_byte;
              res_o.chip_select   = 1'b0;
            end
          end
          PH_CMD_RX: begin
            ring_we        = 1'b1;
            vld_d[wp_ring] = 1'b1;
            wp_d           = WPW'(wp_ring_inc);
            res_push_o     = 1'b1;
            if (left_dec != 8'd0) begin
              left_d            = left_dec;
              res_o.kind        = KIND_XFER;
              res_o.chip_select = 1'b0;
            end else begin
              ctrl_d[EXEC_BIT] = 1'b0;
              phase_d          = PH_IDLE;
              left_d           = 8'd0;
              res_o.kind       = KIND_DONE;
            end
          end
          PH_DA_HDR: begin
            res_push_o        = 1'b1;
            res_o.kind        = KIND_XFER;
            res_o.chip_select = 1'b0;
            if (left_q != 8'd0) begin
              left_d = left_dec;
              case (hdr_sel)
                2'd0:    res_o.transmit_byte = paddr_q[7:0];
                2'd1:    res_o.transmit_byte = paddr_q[15:8];
                2'd2:    res_o.transmit_byte = paddr_q[23:16];
                default: res_o.transmit_byte = 8'd0;
              endcase
            end else begin
              // Address sent; the stored size picks how many data bytes follow
              left_d  = 8'(wp_q[2:0]) + 8'd1;
              wp_d    = '0;
              phase_d = PH_DA_DATA;
            end
          end
          PH_DA_DATA: begin
            word_d     = word_q | (64'(cmd_i.reply) << {wp_q[2:0], 3'b000});
            wp_d       = WPW'(wp_q[2:0] + 3'd1);
            left_d     = left_dec;
            res_push_o = 1'b1;
            if (left_dec != 8'd0) begin
              res_o.kind        = KIND_XFER;
              res_o.chip_select = 1'b0;
            end else begin
              phase_d         = PH_IDLE;
              res_o.kind      = KIND_READ;
              res_o.read_data = word_d;
            end
          end
          default: begin
            // Reply with no transfer outstanding: drop
          end
        endcase
      end else if (phase_q == PH_IDLE) begin
        case (cmd_i.kind)
          CMD_REG_READ: begin
            res_push_o = 1'b1;
            case (cmd_i.regsel)
              REG_CTRL0: res_o.read_data = {32'd0, ctrl_q};
              REG_CTRL1: begin
                rp_d            = rp_inc;
                rp_ext          = WPW'(rp_inc);
                res_o.read_data = {53'd0, rp_ext[2:0], ring_byte};
              end
              default: res_o.read_data = 64'd0;
            endcase
          end
          CMD_REG_WRITE: begin
            case (cmd_i.regsel)
              REG_CTRL0: begin
                if (cw[CLEAR_BIT]) begin
                  rp_d          = '0;
                  cw[CLEAR_BIT] = 1'b0;
                end
                ctrl_d = cw;
                if (cw[EXEC_BIT]) begin
                  wp_d                = WPW'(rp_d);
                  left_d              = 8'd0;
                  phase_d             = PH_CMD_OP;
                  res_push_o          = 1'b1;
                  res_o.kind          = KIND_XFER;
                  res_o.transmit_byte = cw[7:0];
                  res_o.chip_select   = 1'b0;
                end
              end
              REG_EXT_INDEX: ext_idx_d = cmd_i.data[7:0];
              REG_EXT_DATA: begin
                if (ext_idx_q == EXT_SEND_COUNT) begin
                  send_d = cmd_i.data[7:0];
                end else if (ext_idx_q == EXT_RECV_COUNT) begin
                  recv_d = cmd_i.data[7:0];
                end
              end
              default: begin
              end
            endcase
          end
          CMD_DIRECT_READ: begin
            paddr_d             = cmd_i.address;
            word_d              = 64'd0;
            wp_d                = WPW'(cmd_i.size_m1);
            left_d              = 8'd3;
            phase_d             = PH_DA_HDR;
            res_push_o          = 1'b1;
            res_o.kind          = KIND_XFER;
            res_o.transmit_byte = READ_OPCODE;
            res_o.chip_select   = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    // Prefetch the ring byte the next step may need
    if (phase_d == PH_CMD_OP || phase_d == PH_CMD_TX) begin
      ring_raddr = wp_d[PW-1:0];
    end else begin
      ring_raddr = rp_d;
    end
    rvld_d = vld_q[ring_raddr];

    // The RAM returns the old byte when it is written at the address being read
    byp_d      = ring_we && (wp_ring == ring_raddr);
    byp_data_d = cmd_i.reply;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      ctrl_q     <= '0;
      rp_q       <= '0;
      ext_idx_q  <= '0;
      send_q     <= '0;
      recv_q     <= '0;
      left_q     <= '0;
      wp_q       <= '0;
      word_q     <= '0;
      paddr_q    <= '0;
      vld_q      <= '0;
      rvld_q     <= 1'b0;
      byp_q      <= 1'b0;
      byp_data_q <= '0;
    end else begin
      phase_q    <= phase_d;
      ctrl_q     <= ctrl_d;
      rp_q       <= rp_d;
      ext_idx_q  <= ext_idx_d;
      send_q     <= send_d;
      recv_q     <= recv_d;
      left_q     <= left_d;
      wp_q       <= wp_d;
      word_q     <= word_d;
      paddr_q    <= paddr_d;
      vld_q      <= vld_d;
      rvld_q     <= rvld_d;
      byp_q      <= byp_d;
      byp_data_q <= byp_data_d;
    end
  end

  sfc_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_ring),
    .wdata_i (cmd_i.reply),
    .raddr_i (ring_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* src/sfc_checker.sv */
`include "assert_macros.svh"

module sfc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input sfc_pkg::sfc_out_t out_item_o
);

  import sfc_pkg::*;

  `SFC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, (!empty && !pop), (!empty && $stable(out_item_o)), "result changed while stalled")
  `SFC_ASSERT_IMPL(a_full_after_push, clk_i, rst_ni, $rose(full), $past(push), "full rose without a push")
  `SFC_ASSERT_IMPL(a_xfer_fields, clk_i, rst_ni, (!empty && out_item_o.kind == KIND_XFER), (out_item_o.chip_select == 1'b0 && out_item_o.read_data == 64'd0), "transfer with chip select high or data")
  `SFC_ASSERT_IMPL(a_other_fields, clk_i, rst_ni, (!empty && out_item_o.kind != KIND_XFER), (out_item_o.chip_select == 1'b1 && out_item_o.transmit_byte == 8'd0 && (out_item_o.kind == KIND_READ || out_item_o.kind == KIND_DONE)), "bad non-transfer result")

endmodule

bind spi_flash_command_controller_core sfc_checker u_sfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

/* test/tb_top.sv */
module tb_top;
  import sfc_pkg::*;

  // Stop stimulus after this many random transactions that the block acts on.
  localparam int RANDOM_ITEMS = 400;
  // Hard stop for a hung run, far beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Receiver hold-off, long enough to back up both internal queues.
  localparam int HOLD_OFF_CYCLES = 80;
  // Cycles to keep watching for stray results once nothing is due.
  localparam int DRAIN_CYCLES = 20;
  // An offset that decodes to no register.
  localparam logic [23:0] OFS_UNUSED = 24'h00007F;
  // Opcode 0x9F with execute, fifo-clear and every asserted-zero bit set.
  localparam logic [31:0] CMD_WORD = 32'h90F9_009F;
  // The same word as read back: fifo-clear and execute self-clear.
  localparam logic [31:0] CMD_WORD_DONE = 32'h90E8_009F;

  // Sequencer phases of the predictor.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_OPCODE,
    SEQ_SEND,
    SEQ_RECV,
    SEQ_HEADER,
    SEQ_DATA
  } seq_e;

  // One line of the directed script; want is only meaningful when typed is set.
  typedef struct packed {
    sfc_in_t  item;
    logic     typed;
    sfc_out_t want;
  } script_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  logic     empty;
  logic     pop;
  sfc_in_t  in_item;
  sfc_out_t out_item;

  // Predicted controller state, kept in step with accepted transactions.
  logic [31:0] ctl_word    = '0;
  logic [2:0]  rd_ptr      = '0;
  logic [7:0]  ring_mem [8];
  logic [7:0]  param_byte  = '0;
  logic [7:0]  ext_idx     = '0;
  logic [7:0]  tx_count    = '0;
  logic [7:0]  rx_count    = '0;
  seq_e        seq_phase   = SEQ_IDLE;
  logic [8:0]  xfers_left  = '0;
  logic [2:0]  walk_ptr    = '0;
  logic [63:0] assembled   = '0;
  logic [23:0] flash_addr  = '0;

  // Results the block owes us, oldest first.
  sfc_out_t    flash_results_due [$];
  script_row_t script [$];

  int          mismatches    = 0;
  int          results_seen  = 0;
  int unsigned cycle_count   = 0;
  bit          sender_quiet  = 1'b0;

  spi_flash_command_controller_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic sfc_out_t flash_result(logic [1:0] kind, logic [63:0] data,
                                            logic [7:0] tx, logic cs);
    sfc_out_t r;
    r.kind          = kind;
    r.read_data     = data;
    r.transmit_byte = tx;
    r.chip_select   = cs;
    return r;
  endfunction

  // Close a command: drop execute, release chip select.
  function automatic sfc_out_t end_command();
    ctl_word[EXEC_BIT] = 1'b0;
    seq_phase          = SEQ_IDLE;
    xfers_left         = '0;
    return flash_result(KIND_DONE, 64'd0, 8'd0, 1'b1);
  endfunction

  // Advance the predicted controller by one accepted transaction.
  function automatic void predict_flash_step(input sfc_in_t it, output bit made,
                                             output sfc_out_t res);
    int         sh;
    logic [3:0] size;
    made = 1'b1;
    res  = '0;
    if (it.operation == OP_REPLY) begin
      case (seq_phase)
        SEQ_OPCODE, SEQ_SEND: begin
          if (seq_phase == SEQ_OPCODE) xfers_left = {1'b0, tx_count};
          if (xfers_left != 9'd0) begin
            res        = flash_result(KIND_XFER, 64'd0, ring_mem[walk_ptr], 1'b0);
            walk_ptr   = walk_ptr + 3'd1;
            xfers_left = xfers_left - 9'd1;
            seq_phase  = SEQ_SEND;
          end else begin
            // Send part over: receive into the ring where sending stopped.
            rd_ptr     = walk_ptr;
            xfers_left = {1'b0, rx_count};
            if (xfers_left == 9'd0) begin
              res = end_command();
            end else begin
              seq_phase = SEQ_RECV;
              res       = flash_result(KIND_XFER, 64'd0, 8'd0, 1'b0);
            end
          end
        end
        SEQ_RECV: begin
          ring_mem[walk_ptr] = it.reply_byte;
          walk_ptr           = walk_ptr + 3'd1;
          if (xfers_left != 9'd0) xfers_left = xfers_left - 9'd1;
          if (xfers_left != 9'd0) res = flash_result(KIND_XFER, 64'd0, 8'd0, 1'b0);
          else res = end_command();
        end
        SEQ_HEADER: begin
          if (xfers_left != 9'd0) begin
            // Address goes out most significant byte first.
            sh         = 8 * int'((xfers_left - 9'd1) & 9'd3);
            xfers_left = xfers_left - 9'd1;
            res        = flash_result(KIND_XFER, 64'd0, 8'(flash_addr >> sh), 1'b0);
          end else begin
            xfers_left = {6'd0, walk_ptr} + 9'd1;
            walk_ptr   = '0;
            seq_phase  = SEQ_DATA;
            res        = flash_result(KIND_XFER, 64'd0, 8'd0, 1'b0);
          end
        end
        SEQ_DATA: begin
          assembled = assembled | ({56'd0, it.reply_byte} << (8 * walk_ptr));
          walk_ptr  = walk_ptr + 3'd1;
          if (xfers_left != 9'd0) xfers_left = xfers_left - 9'd1;
          if (xfers_left != 9'd0) begin
            res = flash_result(KIND_XFER, 64'd0, 8'd0, 1'b0);
          end else begin
            seq_phase = SEQ_IDLE;
            res       = flash_result(KIND_READ, assembled, 8'd0, 1'b1);
          end
        end
        default: made = 1'b0;
      endcase
    end else if (seq_phase != SEQ_IDLE) begin
      // Bus traffic during a transfer sequence is dropped.
      made = 1'b0;
    end else if (it.operation == OP_REG_READ) begin
      if (it.address == OFS_CTRL0) begin
        res = flash_result(KIND_READ, {32'd0, ctl_word}, 8'd0, 1'b1);
      end else if (it.address == OFS_CTRL1) begin
        param_byte = ring_mem[rd_ptr];
        rd_ptr     = rd_ptr + 3'd1;
        res        = flash_result(KIND_READ, {53'd0, rd_ptr, param_byte}, 8'd0, 1'b1);
      end else begin
        res = flash_result(KIND_READ, 64'd0, 8'd0, 1'b1);
      end
    end else if (it.operation == OP_REG_WRITE) begin
      made = 1'b0;
      if (it.address == OFS_CTRL0) begin
        ctl_word = it.write_data;
        if (ctl_word[CLEAR_BIT]) begin
          rd_ptr              = '0;
          ctl_word[CLEAR_BIT] = 1'b0;
        end
        if (ctl_word[EXEC_BIT]) begin
          walk_ptr   = rd_ptr;
          xfers_left = '0;
          seq_phase  = SEQ_OPCODE;
          made       = 1'b1;
          res        = flash_result(KIND_XFER, 64'd0, ctl_word[7:0], 1'b0);
        end
      end else if (it.address == OFS_EXT_INDEX) begin
        ext_idx = it.write_data[7:0];
      end else if (it.address == OFS_EXT_DATA) begin
        if (ext_idx == EXT_SEND_COUNT) tx_count = it.write_data[7:0];
        else if (ext_idx == EXT_RECV_COUNT) rx_count = it.write_data[7:0];
      end
    end else begin
      // Direct read: clamp the size to 1..8, then opcode and three address bytes.
      size = it.access_size;
      if (size == 4'd0) size = 4'd1;
      if (size > 4'd8) size = 4'd8;
      flash_addr = it.address;
      assembled  = '0;
      walk_ptr   = 3'(size - 4'd1);
      xfers_left = 9'd3;
      seq_phase  = SEQ_HEADER;
      res        = flash_result(KIND_XFER, 64'd0, READ_OPCODE, 1'b0);
    end
  endfunction

  // Draw the next random transaction. While a sequence runs, mostly feed it
  // replies; while idle, mix bus accesses, commands and direct reads.
  function automatic sfc_in_t random_flash_item(output bit counted);
    sfc_in_t it;
    int      roll;
    it.operation   = OP_REG_READ;
    it.address     = 24'($urandom_range(0, 127));
    it.write_data  = $urandom;
    it.access_size = 4'($urandom_range(0, 15));
    it.reply_byte  = 8'($urandom_range(0, 255));
    counted        = 1'b1;
    roll           = $urandom_range(0, 99);
    if (seq_phase != SEQ_IDLE) begin
      if (roll < 90) begin
        it.operation = OP_REPLY;
      end else begin
        it.operation = 2'($urandom_range(0, 2));
        counted      = 1'b0;
      end
    end else if (roll < 8) begin
      it.operation = OP_REPLY;
      counted      = 1'b0;
    end else if (roll < 20) begin
      it.address = roll[0] ? OFS_CTRL0 : OFS_CTRL1;
    end else if (roll < 28) begin
      if (roll < 22) it.address = 24'($urandom);
    end else if (roll < 40) begin
      it.operation = OP_REG_WRITE;
      it.address   = OFS_EXT_INDEX;
      case ($urandom_range(0, 2))
        0:       it.write_data[7:0] = EXT_SEND_COUNT;
        1:       it.write_data[7:0] = EXT_RECV_COUNT;
        default: ;
      endcase
    end else if (roll < 52) begin
      // Keep byte counts short, with an occasional run past the ring size.
      it.operation       = OP_REG_WRITE;
      it.address         = OFS_EXT_DATA;
      it.write_data[7:0] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 20))
                                                       : 8'($urandom_range(0, 6));
    end else if (roll < 76) begin
      it.operation            = OP_REG_WRITE;
      it.address              = OFS_CTRL0;
      it.write_data[EXEC_BIT] = (roll < 70);
    end else if (roll < 82) begin
      it.operation = OP_REG_WRITE;
    end else begin
      it.operation = OP_DIRECT_READ;
      it.address   = 24'($urandom);
    end
    return it;
  endfunction

  function automatic void row(logic [1:0] op, logic [23:0] addr, logic [31:0] data,
                              logic [3:0] size, logic [7:0] reply, logic typed,
                              sfc_out_t want);
    script_row_t r;
    r.item  = {op, addr, data, size, reply};
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  // Present one transaction, now and then after a gap with push low, and hold it until taken.
  task automatic offer(input sfc_in_t it);
    int gap;
    gap = 0;
    if (!sender_quiet && $urandom_range(0, 99) < 19) gap = 1;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: directed script, then random traffic, then drain and verdict.
  initial begin
    sfc_in_t  it;
    sfc_out_t res;
    bit       made;
    bit       counts;
    bit       drained;
    int       accepted_items;
    drained        = 1'b0;
    accepted_items = 0;
    foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;

    // Out of reset: registers read as zero; control 1 returns ring byte 0 and
    // the advanced pointer.
    row(OP_REG_READ, OFS_CTRL0, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_READ, 64'd0, 8'd0, 1'b1));
    row(OP_REG_READ, OFS_CTRL1, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_READ, 64'h100, 8'd0, 1'b1));
    row(OP_REG_READ, OFS_UNUSED, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_READ, 64'd0, 8'd0, 1'b1));
    // Unknown extension index: the data write must not touch either count.
    row(OP_REG_WRITE, OFS_EXT_INDEX, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b0, '0);
    row(OP_REG_WRITE, OFS_EXT_DATA, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b0, '0);
    // Two bytes out, three bytes back.
    row(OP_REG_WRITE, OFS_EXT_INDEX, {24'd0, EXT_SEND_COUNT}, 4'd0, 8'd0, 1'b0, '0);
    row(OP_REG_WRITE, OFS_EXT_DATA, 32'h0000_0002, 4'd0, 8'd0, 1'b0, '0);
    row(OP_REG_WRITE, OFS_EXT_INDEX, {24'd0, EXT_RECV_COUNT}, 4'd0, 8'd0, 1'b0, '0);
    row(OP_REG_WRITE, OFS_EXT_DATA, 32'h0000_0003, 4'd0, 8'd0, 1'b0, '0);
    // Reply with nothing in flight is dropped.
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'hFF, 1'b0, '0);
    // Execute with fifo-clear: pointer back to zero, opcode goes out first.
    row(OP_REG_WRITE, OFS_CTRL0, CMD_WORD, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_XFER, 64'd0, 8'h9F, 1'b0));
    // Bus access while busy is dropped.
    row(OP_DIRECT_READ, 24'hFFFFFF, 32'd0, 4'd8, 8'd0, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h11, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h22, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h33, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'hA5, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h5A, 1'b0, '0);
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'hC3, 1'b1,
        flash_result(KIND_DONE, 64'd0, 8'd0, 1'b1));
    row(OP_REG_READ, OFS_CTRL0, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_READ, {32'd0, CMD_WORD_DONE}, 8'd0, 1'b1));
    // First received byte landed at pointer 2.
    row(OP_REG_READ, OFS_CTRL1, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_READ, 64'h3A5, 8'd0, 1'b1));
    // Direct read at the top address with size zero, treated as one byte.
    row(OP_DIRECT_READ, 24'hFFFFFF, 32'd0, 4'd0, 8'd0, 1'b1,
        flash_result(KIND_XFER, 64'd0, READ_OPCODE, 1'b0));
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h00, 1'b1,
        flash_result(KIND_XFER, 64'd0, 8'hFF, 1'b0));
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h00, 1'b1,
        flash_result(KIND_XFER, 64'd0, 8'hFF, 1'b0));
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h00, 1'b1,
        flash_result(KIND_XFER, 64'd0, 8'hFF, 1'b0));
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h00, 1'b1,
        flash_result(KIND_XFER, 64'd0, 8'd0, 1'b0));
    row(OP_REPLY, 24'd0, 32'd0, 4'd0, 8'h5C, 1'b1,
        flash_result(KIND_READ, 64'h5C, 8'd0, 1'b1));

    // Hold reset, then release it on a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Typed rows are trusted as written; the predictor still runs on them so
    // its state stays in step.
    foreach (script[i]) begin
      offer(script[i].item);
      predict_flash_step(script[i].item, made, res);
      if (script[i].typed) flash_results_due.push_back(script[i].want);
      else if (made) flash_results_due.push_back(res);
    end

    while (accepted_items < RANDOM_ITEMS) begin
      // Pause once until every owed result has come back.
      if (accepted_items == 300 && !drained) begin
        drained = 1'b1;
        push <= 1'b0;
        do @(posedge clk_i); while (flash_results_due.size() != 0);
      end
      // Run back to back for a stretch.
      sender_quiet = (accepted_items >= 100 && accepted_items < 180);
      it = random_flash_item(counts);
      offer(it);
      predict_flash_step(it, made, res);
      if (made) flash_results_due.push_back(res);
      if (counts) accepted_items++;
    end

    // Drain, then keep watching for stray results.
    push <= 1'b0;
    do @(posedge clk_i); while (flash_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Receiver: check each popped transaction against the oldest owed result.
  initial begin
    sfc_out_t want;
    bit       held_off;
    held_off = 1'b0;
    pop <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_seen++;
        if (flash_results_due.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, out_item);
          mismatches++;
        end else begin
          want = flash_results_due.pop_front();
          check_field("kind", {62'd0, want.kind}, {62'd0, out_item.kind});
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("transmit_byte", {56'd0, want.transmit_byte},
                      {56'd0, out_item.transmit_byte});
          check_field("chip_select", {63'd0, want.chip_select},
                      {63'd0, out_item.chip_select});
        end
      end
      // Hold off once so both queues fill and push gets stalled.
      if (results_seen == 60 && !held_off) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      // Idle at random, except for a stretch of steady popping.
      pop <= (results_seen >= 150 && results_seen < 260) || ($urandom_range(0, 99) >= 16);
    end
  end

endmodule

/* filelist.f */
+incdir+src
src/sfc_pkg.sv
src/sfc_ram.sv
src/sfc_fifo.sv
src/sfc_front.sv
src/sfc_back.sv
src/spi_flash_command_controller_core.sv
src/sfc_checker.sv
test/tb_top.sv
